FILE: rtl/qpd_pkg.sv
// Shared constants and helper function for the quoted-printable decoder.
package qpd_pkg;

    // Largest decoded length reported; the count saturates here or at 16 bits.
    localparam longint unsigned MAX_LEN   = 64'd65535;
    localparam logic [15:0]     COUNT_LIM = (MAX_LEN > 64'd65535) ? 16'hFFFF
                                                                  : MAX_LEN[15:0];

    // Special characters of the encoding.
    localparam logic [7:0] CHAR_EQ = 8'h3D;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Digit value that marks a character that is not a hex digit.
    localparam logic [4:0] NOT_HEX = 5'd16;

    typedef logic [4:0] t_digit;

    // Map one character to its hex digit value, either case.
    function automatic t_digit hex_value(input logic [7:0] c);
        t_digit v;
        v = NOT_HEX;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = t_digit'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = t_digit'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = t_digit'(c - 8'h61 + 8'd10);
        end
        return v;
    endfunction

endpackage

FILE: rtl/quoted_printable_decoder_core.sv
// Quoted-printable decoder core: input register, decode step, result register.
//
// Takes one encoded byte per beat and returns exactly one result beat per input
// beat, sustaining one byte per clock cycle while the output is not stalled. An
// accepted beat is held in the input register, then decoded into the result
// register, where it stays until the output takes it. The decode step and its
// escape state update sit between the input register and the result register,
// so a new byte can enter every cycle while the output is not stalled; while the
// output is stalled, one further beat is still taken into the input
// register. Results carry byte_valid (0 while an escape or soft line break is
// absorbed), the decoded byte, the end-of-text flag, and on the last beat the
// saturating count of bytes decoded in the string. The escape state and count
// return to reset after each end-of-text beat.
module quoted_printable_decoder_core
    import qpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_byte_valid,
    output logic [7:0]  o_decoded_byte,
    output logic        o_is_last,
    output logic [15:0] o_decoded_count
);

    typedef enum logic [1:0] {
        PH_TEXT  = 2'd0,
        PH_EQ    = 2'd1,
        PH_EQ_CR = 2'd2,
        PH_DIGIT = 2'd3
    } t_phase;

    t_phase      r_phase, n_phase;
    t_digit      r_first, n_first;
    logic [15:0] r_count, n_count;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic        r_out_valid;
    logic        r_out_bvalid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [15:0] r_out_count;

    logic        in_accept;
    logic        advance;
    logic        dec_valid;
    logic [7:0]  dec_byte;
    logic [15:0] cnt_inc;
    t_digit      cur_digit;

    // Stage moves when the result register is free or being emptied.
    assign advance    = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Decode one byte against the escape state.
    always_comb begin
        n_phase   = r_phase;
        n_first   = r_first;
        dec_valid = 1'b0;
        dec_byte  = 8'h00;
        cur_digit = hex_value(r_in_byte);
        case (r_phase)
            PH_TEXT: begin
                if (r_in_byte == CHAR_EQ) begin
                    n_phase = PH_EQ;
                end else begin
                    dec_valid = 1'b1;
                    dec_byte  = r_in_byte;
                end
            end
            PH_EQ, PH_EQ_CR: begin
                if (r_phase == PH_EQ && r_in_byte == CHAR_CR) begin
                    n_phase = PH_EQ_CR;
                end else if (r_in_byte == CHAR_LF) begin
                    n_phase = PH_TEXT;
                end else begin
                    n_first = cur_digit;
                    n_phase = PH_DIGIT;
                end
            end
            PH_DIGIT: begin
                dec_valid = 1'b1;
                if (r_first == NOT_HEX) begin
                    dec_byte = 8'h00;
                end else if (cur_digit == NOT_HEX) begin
                    dec_byte = {4'h0, r_first[3:0]};
                end else begin
                    dec_byte = {r_first[3:0], cur_digit[3:0]};
                end
                n_first = '0;
                n_phase = PH_TEXT;
            end
            default: begin
                n_phase = PH_TEXT;
            end
        endcase

        // Count decoded bytes, holding at the limit.
        cnt_inc = (dec_valid && r_count < COUNT_LIM) ? 16'd1 : 16'd0;
        n_count = r_count + cnt_inc;
    end

    // Hold state and registers; advance the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TEXT;
            r_first     <= '0;
            r_count     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // input register
            if (in_accept) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_text_byte;
                r_in_last  <= i_end_of_text;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            // decode step and result register
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_out_bvalid <= dec_valid;
                r_out_byte   <= dec_byte;
                r_out_last   <= r_in_last;
                r_out_count  <= r_in_last ? n_count : 16'd0;
                if (r_in_last) begin
                    r_phase <= PH_TEXT;
                    r_first <= '0;
                    r_count <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_first <= n_first;
                    r_count <= n_count;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_valid    = r_out_bvalid;
    assign o_decoded_byte  = r_out_byte;
    assign o_is_last       = r_out_last;
    assign o_decoded_count = r_out_count;

endmodule

FILE: rtl/qpd_checker.sv
// Port-level checks for the quoted-printable decoder and their binding.
module qpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_byte_valid,
    input logic [7:0]  o_decoded_byte,
    input logic        o_is_last,
    input logic [15:0] o_decoded_count
);

    // A stalled result beat stays valid and keeps its decoded byte and count.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_decoded_byte) && $stable(o_decoded_count))
        else $error("result beat changed while stalled");

    // Input stalls only while a result beat waits on a stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // An empty result carries a zero byte.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_decoded_byte == 8'h00)
        else $error("nonzero byte on empty result");

    // The count shows only on the last beat of a string.
    a_count_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_last |-> o_decoded_count == 16'd0)
        else $error("count reported before end of text");

endmodule

bind quoted_printable_decoder_core qpd_checker u_qpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_byte_valid   (o_byte_valid),
    .o_decoded_byte (o_decoded_byte),
    .o_is_last      (o_is_last),
    .o_decoded_count(o_decoded_count)
);

FILE: bench/tb.sv
// Self-checking testbench for the quoted-printable decoder core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qpd_pkg::*;

    // Decoder phase as tracked by the predictor
    typedef enum logic [1:0] {QP_TEXT, QP_EQ, QP_EQ_CR, QP_DIGIT} t_qp_phase;

    // One result beat
    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  decoded_byte;
        logic        is_last;
        logic [15:0] decoded_count;
    } t_qp_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_text_byte = 8'h00;
    logic        i_end_of_text = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_byte_valid;
    logic [7:0]  o_decoded_byte;
    logic        o_is_last;
    logic [15:0] o_decoded_count;

    // Predictor state
    t_qp_phase   dec_phase = QP_TEXT;
    logic [4:0]  dec_first = 5'd0;
    logic [15:0] dec_count = 16'd0;

    t_qp_result  expected_results[$];
    logic [7:0]  text_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int beats_sent = 0;
    int strings_sent = 0;

    quoted_printable_decoder_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_text_byte     (i_text_byte),
        .i_end_of_text   (i_end_of_text),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_byte_valid    (o_byte_valid),
        .o_decoded_byte  (o_decoded_byte),
        .o_is_last       (o_is_last),
        .o_decoded_count (o_decoded_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Value of a hex digit in either case; bit 4 set when not a digit
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b0, c[3:0]};
        end
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10) begin
            return "0" + 8'(v);
        end
        return (upper ? "A" : "a") + 8'(v - 4'd10);
    endfunction

    // Advance the predictor by one accepted beat and queue its result
    task automatic decode_predict(input logic [7:0] b, input logic eot);
        t_qp_result r;
        logic [4:0] d;
        r = '0;
        case (dec_phase)
            QP_TEXT: begin
                if (b == CHAR_EQ) begin
                    dec_phase = QP_EQ;
                end else begin
                    r.byte_valid = 1'b1;
                    r.decoded_byte = b;
                end
            end
            QP_EQ, QP_EQ_CR: begin
                if (dec_phase == QP_EQ && b == CHAR_CR) begin
                    dec_phase = QP_EQ_CR;
                end else if (b == CHAR_LF) begin
                    dec_phase = QP_TEXT;
                end else begin
                    dec_first = digit_of(b);
                    dec_phase = QP_DIGIT;
                end
            end
            default: begin
                d = digit_of(b);
                if (dec_first[4]) begin
                    r.decoded_byte = 8'h00;
                end else if (d[4]) begin
                    r.decoded_byte = {4'h0, dec_first[3:0]};
                end else begin
                    r.decoded_byte = {dec_first[3:0], d[3:0]};
                end
                r.byte_valid = 1'b1;
                dec_first = 5'd0;
                dec_phase = QP_TEXT;
            end
        endcase
        if (r.byte_valid && dec_count < COUNT_LIM) begin
            dec_count = dec_count + 16'd1;
        end
        r.is_last = eot;
        r.decoded_count = eot ? dec_count : 16'd0;
        if (eot) begin
            dec_phase = QP_TEXT;
            dec_first = 5'd0;
            dec_count = 16'd0;
        end
        expected_results.push_back(r);
    endtask

    // Drive one beat, with a random gap ahead of it, and hold it until taken
    task automatic send_beat(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_text_byte <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        decode_predict(b, eot);
        beats_sent++;
    endtask

    // Send text_q as one string, end-of-text on its last byte
    task automatic send_string();
        for (int i = 0; i < text_q.size(); i++) begin
            send_beat(text_q[i], i == text_q.size() - 1);
        end
        strings_sent++;
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic report_fail(input string what, input t_qp_result exp_r);
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%t %s: exp %0b/%02h/%0b/%0d got %0b/%02h/%0b/%0d",
                     $realtime, what, exp_r.byte_valid, exp_r.decoded_byte, exp_r.is_last,
                     exp_r.decoded_count, o_byte_valid, o_decoded_byte, o_is_last,
                     o_decoded_count);
        end
    endtask

    // Compare one accepted result beat against the oldest expectation
    task automatic check_result();
        t_qp_result exp_r;
        if (expected_results.size() == 0) begin
            report_fail("unexpected result", '0);
            return;
        end
        exp_r = expected_results.pop_front();
        results_checked++;
        if (o_byte_valid !== exp_r.byte_valid || o_decoded_byte !== exp_r.decoded_byte ||
            o_is_last !== exp_r.is_last || o_decoded_count !== exp_r.decoded_count) begin
            report_fail("result mismatch", exp_r);
        end
    endtask

    // Output side: random stall, check each beat taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_result();
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic test_plain_bytes();
        text_q = {8'h00, 8'hFF};
        send_string();
    endtask

    task automatic test_hex_escapes();
        text_q = {CHAR_EQ, "F", "f", CHAR_EQ, "0", "9", CHAR_EQ, "a", "B"};
        send_string();
        drain();
    endtask

    task automatic test_soft_breaks();
        text_q = {CHAR_EQ, CHAR_LF, CHAR_EQ, CHAR_CR, CHAR_LF};
        send_string();
    endtask

    // Bad first digit, bad second digit, CR after '=' without LF
    task automatic test_malformed_escapes();
        text_q = {CHAR_EQ, "G", "1", CHAR_EQ, "4", "Z", CHAR_EQ, CHAR_CR, "A", "5"};
        send_string();
        drain();
    endtask

    task automatic test_unfinished_escape();
        text_q = {CHAR_EQ, "4"};
        send_string();
        text_q = {CHAR_EQ};
        send_string();
    endtask

    // Append one token of a random string: mostly well-formed, some noise
    task automatic add_token();
        int sel;
        logic [7:0] c;
        sel = $urandom_range(99);
        c = 8'($urandom_range(255));
        if (sel < 45) begin
            text_q.push_back(c == CHAR_EQ ? 8'h20 : c);
        end else if (sel < 70) begin
            text_q.push_back(CHAR_EQ);
            text_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            text_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        end else if (sel < 82) begin
            text_q.push_back(CHAR_EQ);
            if ($urandom_range(1)) begin
                text_q.push_back(CHAR_CR);
            end
            text_q.push_back(CHAR_LF);
        end else if (sel < 92) begin
            text_q.push_back(CHAR_EQ);
            text_q.push_back(c);
            text_q.push_back(8'($urandom_range(255)));
        end else begin
            text_q.push_back(c);
        end
    endtask

    task automatic test_random_strings(input int n_beats);
        int stop_at;
        int n_tok;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            text_q.delete();
            n_tok = $urandom_range(1, 12);
            for (int t = 0; t < n_tok; t++) begin
                add_token();
            end
            // Sometimes end the string inside an escape
            if ($urandom_range(9) == 0) begin
                text_q.push_back(CHAR_EQ);
                if ($urandom_range(1)) begin
                    text_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
                end
            end
            send_string();
            if ($urandom_range(15) == 0) begin
                drain();
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender mostly busy, receiver stalls often
        send_idle_pct = 12;
        recv_idle_pct = 56;
        test_plain_bytes();
        test_hex_escapes();
        test_soft_breaks();
        test_malformed_escapes();
        test_unfinished_escape();
        drain();
        test_random_strings(230);
        drain();

        // Sender gaps often, receiver rarely stalls
        send_idle_pct = 56;
        recv_idle_pct = 12;
        test_random_strings(240);
        drain();

        // Full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_strings(240);
        drain();

        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            fail_count++;
        end
        $display("Decoded %0d strings in %0d beats; %0d results checked, %0d mismatches.",
                 strings_sent, beats_sent, results_checked, mismatch_count);
        $display("Covered escapes, soft breaks, malformed and cut-off escapes, stalls both ways.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding.", expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
rtl/qpd_pkg.sv
rtl/quoted_printable_decoder_core.sv
rtl/qpd_checker.sv
bench/tb.sv
